// ===== rtl/acpis5_pkg.sv =====
// types and constants shared by the _S5_ sleep-type scanner
package acpis5_pkg;

    localparam logic [7:0] CHAR_UNDERSCORE = 8'h5F;
    localparam logic [7:0] CHAR_S          = 8'h53;
    localparam logic [7:0] CHAR_FIVE       = 8'h35;
    localparam logic [7:0] OP_PACKAGE      = 8'h12;
    localparam logic [7:0] OP_BYTE_PREFIX  = 8'h0A;
    localparam logic [15:0] SLP_EN         = 16'h2000;
    localparam int unsigned SLP_SHIFT      = 10;
    localparam int unsigned LEAD_SHIFT     = 6;

    typedef enum logic [3:0] {
        PH_IDLE  = 4'd0,
        PH_U     = 4'd1,
        PH_US    = 4'd2,
        PH_US5   = 4'd3,
        PH_NAME  = 4'd4,
        PH_LEAD  = 4'd5,
        PH_SKIP  = 4'd6,
        PH_COUNT = 4'd7,
        PH_A     = 4'd8,
        PH_A_PFX = 4'd9,
        PH_B     = 4'd10,
        PH_B_PFX = 4'd11,
        PH_WAIT  = 4'd12
    } phase_t;

    typedef struct packed {
        logic [7:0] aml_byte;
        logic       is_last;
    } aml_item_t;

    typedef struct packed {
        logic        found;
        logic [7:0]  sleep_type_a;
        logic [7:0]  sleep_type_b;
        logic [15:0] control_word_a;
        logic [15:0] control_word_b;
    } s5_result_t;

    typedef struct packed {
        logic       valid;
        s5_result_t data;
    } step_result_t;

    function automatic logic [15:0] control_word(input logic [7:0] typ);
        logic [15:0] shifted;
        shifted = 16'(typ) << SLP_SHIFT;
        return shifted | SLP_EN;
    endfunction

endpackage

// ===== rtl/acpis5_fsm.sv =====
// byte-stream recogniser: phase register, skip counter and held sleep type
module acpis5_fsm (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      fire,
    input  acpis5_pkg::aml_item_t     item,
    output acpis5_pkg::step_result_t  step
);
    import acpis5_pkg::*;

    phase_t      phase_reg, phase_next;
    logic [1:0]  skip_reg, skip_next;
    logic [7:0]  held_a_reg, held_a_next;

    function automatic phase_t match_name(input phase_t ph, input logic [7:0] c);
        phase_t res;
        case (ph)
            PH_U, PH_NAME:
                res = (c == CHAR_S) ? PH_US :
                      ((c == CHAR_UNDERSCORE) ? PH_U : PH_IDLE);
            PH_US:
                res = (c == CHAR_FIVE) ? PH_US5 :
                      ((c == CHAR_UNDERSCORE) ? PH_U : PH_IDLE);
            PH_US5:
                res = (c == CHAR_UNDERSCORE) ? PH_NAME : PH_IDLE;
            default:
                res = (c == CHAR_UNDERSCORE) ? PH_U : PH_IDLE;
        endcase
        return res;
    endfunction

    function automatic step_result_t make_result(input logic found,
                                                 input logic [7:0] a,
                                                 input logic [7:0] b);
        step_result_t r;
        r.valid               = 1'b1;
        r.data.found          = found;
        r.data.sleep_type_a   = a;
        r.data.sleep_type_b   = b;
        r.data.control_word_a = control_word(a);
        r.data.control_word_b = control_word(b);
        return r;
    endfunction

    always_comb
    begin
        logic [7:0] c;
        logic [1:0] dec;
        c           = item.aml_byte;
        dec         = skip_reg - 2'd1;
        phase_next  = phase_reg;
        skip_next   = skip_reg;
        held_a_next = held_a_reg;
        step        = '0;
        case (phase_reg)
            PH_NAME:
            begin
                if (c == OP_PACKAGE)
                    phase_next = PH_LEAD;
                else
                    phase_next = match_name(PH_NAME, c);
            end
            PH_LEAD:
            begin
                skip_next  = c[LEAD_SHIFT +: 2];
                phase_next = (c[LEAD_SHIFT +: 2] == 2'd0) ? PH_COUNT : PH_SKIP;
            end
            PH_SKIP:
            begin
                skip_next = dec;
                if (dec == 2'd0)
                    phase_next = PH_COUNT;
            end
            PH_COUNT:
                phase_next = PH_A;
            PH_A, PH_A_PFX:
            begin
                if (phase_reg == PH_A && c == OP_BYTE_PREFIX)
                begin
                    phase_next = PH_A_PFX;
                end
                else
                begin
                    held_a_next = c;
                    phase_next  = PH_B;
                    if (item.is_last)
                    begin
                        step       = make_result(1'b1, c, c);
                        phase_next = PH_WAIT;
                    end
                end
            end
            PH_B:
            begin
                if (c == OP_BYTE_PREFIX && !item.is_last)
                begin
                    phase_next = PH_B_PFX;
                end
                else
                begin
                    step = make_result(1'b1, held_a_reg,
                                       (c == OP_BYTE_PREFIX) ? held_a_reg : c);
                    phase_next = PH_WAIT;
                end
            end
            PH_B_PFX:
            begin
                step       = make_result(1'b1, held_a_reg, c);
                phase_next = PH_WAIT;
            end
            PH_WAIT:
                phase_next = PH_WAIT;
            default:
                phase_next = match_name(phase_reg, c);
        endcase

        // end of table: give the not-found result if no result was given yet, and return to reset
        if (item.is_last)
        begin
            if (!step.valid && phase_reg != PH_WAIT)
                step = make_result(1'b0, 8'd0, 8'd0);
            phase_next  = PH_IDLE;
            skip_next   = 2'd0;
            held_a_next = 8'd0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_IDLE;
            skip_reg   <= 2'd0;
            held_a_reg <= 8'd0;
        end
        else if (fire)
        begin
            phase_reg  <= phase_next;
            skip_reg   <= skip_next;
            held_a_reg <= held_a_next;
        end
    end

endmodule

// ===== rtl/acpis5_out_reg.sv =====
// result register holding one transaction until the receiver takes it
module acpis5_out_reg (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    load,
    input  acpis5_pkg::s5_result_t  load_data,
    input  logic                    res_stall,
    output logic                    res_valid,
    output acpis5_pkg::s5_result_t  res
);
    import acpis5_pkg::*;

    logic       valid_reg, valid_next;
    s5_result_t data_reg;

    assign valid_next = load | (valid_reg & res_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (load)
            data_reg <= load_data;
    end

    assign res_valid = valid_reg;
    assign res       = data_reg;

endmodule

// ===== rtl/acpi_s5_sleep_type_scanner_core.sv =====
// top level of the _S5_ sleep-type scanner
//
//  channel | direction | handshake            | payload
//  aml     | in        | aml_valid, aml_stall | aml_item_t  (byte, last mark)
//  res     | out       | res_valid, res_stall | s5_result_t (one per table)
//
//  one byte per cycle while aml_stall is low: input register, one step of the phase logic, result register
//  a byte that yields a result goes from the input register into the result register when it fires
//  reset clears the phase, skip count, held type and both valid flags
//  aml_stall rises only when a byte that yields a result waits on a stalled result
module acpi_s5_sleep_type_scanner_core (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    aml_valid,
    output logic                    aml_stall,
    input  acpis5_pkg::aml_item_t   aml,
    output logic                    res_valid,
    input  logic                    res_stall,
    output acpis5_pkg::s5_result_t  res
);
    import acpis5_pkg::*;

    logic         in_valid_reg, in_valid_next;
    aml_item_t    in_data_reg;
    step_result_t step;
    logic         out_free;
    logic         fire;

    assign out_free      = !res_valid || !res_stall;
    assign fire          = in_valid_reg && (!step.valid || out_free);
    assign aml_stall     = in_valid_reg && !fire;
    assign in_valid_next = aml_stall ? in_valid_reg : aml_valid;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else
            in_valid_reg <= in_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (aml_valid && !aml_stall)
            in_data_reg <= aml;
    end

    acpis5_fsm u_fsm (
        .clk   (clk),
        .rst_n (rst_n),
        .fire  (fire),
        .item  (in_data_reg),
        .step  (step)
    );

    acpis5_out_reg u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (fire && step.valid),
        .load_data (step.data),
        .res_stall (res_stall),
        .res_valid (res_valid),
        .res       (res)
    );

    a_no_stall_when_free: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid_reg && !res_valid |-> !aml_stall)
        else $error("input stalled while result register empty");

    a_enable_bits: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> res.control_word_a[13] && res.control_word_b[13])
        else $error("control word without enable bit");

    a_not_found_zero: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res.found |-> res.sleep_type_a == 8'd0 && res.sleep_type_b == 8'd0)
        else $error("not-found result carries a sleep type");

    a_result_needs_item: assert property (@(posedge clk) disable iff (!rst_n)
        !res_valid ##1 res_valid |-> $past(in_valid_reg))
        else $error("result appeared without a byte in the input register");

endmodule
